>>> sv/jipd_pkg.sv
package jipd_pkg;

    localparam int JOINTS     = 7;
    localparam int JOINT_W    = 3;
    localparam int POS_W      = 18;
    localparam int VEL_W      = 18;
    localparam int TQ_W       = 20;
    localparam int ALPHA_W    = 16;
    localparam int AMP_W      = 15;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Quarter-wave cosine table, Q1.14
    localparam int COS_DEPTH  = 256;
    localparam int COS_FRAC   = 14;
    localparam int COS_MAG_W  = COS_FRAC + 1;
    localparam int COS_ADDR_W = $clog2(COS_DEPTH) + 1;
    localparam int COS_IDX_W  = $clog2(4 * COS_DEPTH);
    localparam int OFS_W      = 16;

    // Shared multiplier and accumulator
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 18;
    localparam int ERR_W   = 20;
    localparam int ACC_W   = 36;
    localparam int KP_W    = 5;
    localparam int KD_W    = 3;

    // Joints whose targets carry the trajectory offset
    localparam logic [JOINT_W-1:0] OFS_JOINT_A = 3'd5;
    localparam logic [JOINT_W-1:0] OFS_JOINT_B = 3'd6;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_AMPLITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS     = 2'd2;

    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd64881;
    localparam logic [AMP_W-1:0]    AMP_RST    = 15'd6434;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd5000;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd2;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SAMPLE,
        OP_PHASE,
        OP_DIV_START,
        OP_COS,
        OP_OFS_MUL,
        OP_OFS,
        OP_MUL1,
        OP_MUL2,
        OP_FILT,
        OP_KP,
        OP_KD,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [JOINT_W-1:0] joint;
    } t_cmd;

    typedef struct packed {
        logic initialized;
        logic div_done;
        logic out_free;
    } t_status;

    typedef logic [COS_MAG_W-1:0] t_cos_tab [0:COS_DEPTH];

    // Unsigned floor quotient by shift and subtract
    function automatic longint unsigned udiv_q(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Taylor series in Q30, rounded half up to Q14
    function automatic logic [COS_MAG_W-1:0] cos_q14(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned mag;
        longint          sum;
        x   = (longint'(k) * HALF_PI_Q30) >> $clog2(COS_DEPTH);
        x2  = (x * x) >> 30;
        mag = 64'd1 << 30;
        sum = longint'(mag);
        for (int n = 1; n <= 7; n++) begin
            mag = udiv_q((mag * x2) >> 30, longint'((2 * n - 1) * (2 * n)));
            if ((n & 1) == 1) begin
                sum = sum - longint'(mag);
            end else begin
                sum = sum + longint'(mag);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 32768) >>> 16;
        if (sum > 16384) begin
            sum = 16384;
        end
        return sum[COS_MAG_W-1:0];
    endfunction

    function automatic t_cos_tab build_cos_tab();
        t_cos_tab tab;
        for (int k = 0; k <= COS_DEPTH; k++) begin
            tab[k] = cos_q14(k);
        end
        return tab;
    endfunction

    function automatic logic [KP_W-1:0] kp_gain(input logic [JOINT_W-1:0] j);
        if (j inside {[3'd0:3'd3]}) begin
            return 5'd24;
        end else if (j == 3'd4) begin
            return 5'd10;
        end else if (j == 3'd5) begin
            return 5'd6;
        end
        return 5'd2;
    endfunction

    // Derivative gain in Q1
    function automatic logic [KD_W-1:0] kd_gain(input logic [JOINT_W-1:0] j);
        if (j inside {[3'd0:3'd2]}) begin
            return 3'd4;
        end else if (j inside {[3'd3:3'd5]}) begin
            return 3'd2;
        end
        return 3'd1;
    endfunction

endpackage

>>> sv/jipd_phase_div.sv
module jipd_phase_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [jipd_pkg::PERIOD_W-1:0]      i_phase,
    input  logic [jipd_pkg::PERIOD_W-1:0]      i_period,
    output logic [jipd_pkg::COS_IDX_W-1:0]     o_quot,
    output logic                               o_done
);
    import jipd_pkg::*;

    localparam int CNT_W = $clog2(COS_IDX_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [PERIOD_W-1:0]   r_rem;
    logic [COS_IDX_W-1:0]  r_quot;

    logic [PERIOD_W:0]     shifted;
    logic [PERIOD_W:0]     diff;
    logic                  ge;

    // Restoring division of phase * 4D by period, one quotient bit a cycle
    always_comb begin
        shifted = {r_rem, 1'b0};
        ge      = shifted >= {1'b0, i_period};
        diff    = shifted - {1'b0, i_period};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COS_IDX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_phase;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
            r_quot <= {r_quot[COS_IDX_W-2:0], ge};
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

>>> sv/jipd_datapath.sv
module jipd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  jipd_pkg::t_cmd                      i_cmd,
    output jipd_pkg::t_status                   o_status,
    input  logic [jipd_pkg::JOINT_W-1:0]        i_joint_index,
    input  logic signed [jipd_pkg::POS_W-1:0]   i_position,
    input  logic signed [jipd_pkg::VEL_W-1:0]   i_velocity,
    input  logic                                i_cfg_valid,
    input  logic [jipd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jipd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic [jipd_pkg::JOINT_W-1:0]        o_out_joint,
    output logic signed [jipd_pkg::TQ_W-1:0]    o_torque,
    output logic                                o_last
);
    import jipd_pkg::*;

    localparam t_cos_tab COS_TAB = build_cos_tab();

    localparam int FILT_SHIFT = 16;
    localparam int TQ_SHIFT   = 4;
    localparam logic signed [ACC_W-1:0] FILT_ROUND = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] TQ_ROUND   = ACC_W'(8);
    localparam logic signed [ACC_W-1:0] OFS_ROUND  = ACC_W'(8192);
    localparam logic [OFS_W:0]          COS_ONE    = (OFS_W + 1)'(16384);
    localparam logic [ALPHA_W:0]        ALPHA_ONE  = (ALPHA_W + 1)'(65536);

    // Configuration and control state
    logic [ALPHA_W-1:0]          r_alpha;
    logic [AMP_W-1:0]            r_amp;
    logic [PERIOD_W-1:0]         r_period;
    logic                        r_init;
    logic [JOINTS-1:0]           r_mask;
    logic [PERIOD_W-1:0]         r_phase;
    logic signed [VEL_W-1:0]     r_filt_mem [JOINTS];
    logic                        r_out_valid;

    // Payload state
    logic signed [POS_W-1:0]     r_meas_pos [JOINTS];
    logic signed [VEL_W-1:0]     r_meas_vel [JOINTS];
    logic signed [POS_W-1:0]     r_start    [JOINTS];
    logic [COS_MAG_W-1:0]        r_cos;
    logic                        r_cos_neg;
    logic [OFS_W-1:0]            r_offset;
    logic signed [ACC_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [ERR_W-1:0]     r_err;
    logic signed [VEL_W-1:0]     r_filt;
    logic [JOINT_W-1:0]          r_out_joint;
    logic signed [TQ_W-1:0]      r_torque;
    logic                        r_out_last;

    logic [JOINT_W-1:0]          jsel;
    logic                        sample_ok;
    logic [JOINTS-1:0]           n_mask;
    logic                        init_now;
    logic [PERIOD_W-1:0]         phase_inc;
    logic [PERIOD_W-1:0]         n_phase;
    logic [COS_IDX_W-1:0]        quot;
    logic                        div_done;
    logic [1:0]                  quadrant;
    logic [COS_ADDR_W-2:0]       quad_off;
    logic [COS_ADDR_W-1:0]       cos_addr;
    logic [OFS_W:0]              omc_full;
    logic [OFS_W-1:0]            one_minus_cos;
    logic [ALPHA_W:0]            inv_alpha;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;
    logic signed [ACC_W-1:0]     ofs_sum;
    logic signed [ACC_W-1:0]     filt_sum;
    logic signed [ACC_W-1:0]     filt_sh;
    logic signed [VEL_W-1:0]     n_filt;
    logic signed [ERR_W-1:0]     target;
    logic signed [ERR_W-1:0]     n_err;
    logic signed [ACC_W-1:0]     tq_sum;
    logic signed [ACC_W-1:0]     tq_sh;
    logic signed [TQ_W-1:0]      n_torque;
    logic                        out_free;
    logic                        out_load;

    assign jsel = i_cmd.joint;

    jipd_phase_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.op == OP_DIV_START),
        .i_phase  (r_phase),
        .i_period (r_period),
        .o_quot   (quot),
        .o_done   (div_done)
    );

    always_comb begin
        sample_ok = i_joint_index < JOINT_W'(JOINTS);
        n_mask    = r_mask | (JOINTS'(1) << i_joint_index);
        init_now  = (i_cmd.op == OP_SAMPLE) && sample_ok && !r_init && (&n_mask);

        phase_inc = r_phase + 1'b1;
        n_phase   = (phase_inc >= r_period) ? '0 : phase_inc;

        // Fold the full-wave index onto the quarter-wave table
        quadrant = quot[COS_IDX_W-1 -: 2];
        quad_off = quot[COS_ADDR_W-2:0];
        cos_addr = quadrant[0] ? (COS_ADDR_W'(COS_DEPTH) - {1'b0, quad_off})
                               : {1'b0, quad_off};

        if (r_period < PERIOD_MIN) begin
            omc_full = '0;
        end else if (r_cos_neg) begin
            omc_full = COS_ONE + (OFS_W + 1)'(r_cos);
        end else begin
            omc_full = COS_ONE - (OFS_W + 1)'(r_cos);
        end
        one_minus_cos = omc_full[OFS_W-1:0];
        inv_alpha     = ALPHA_ONE - {1'b0, r_alpha};
    end

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_OFS_MUL: begin
                mul_a = signed'(MUL_A_W'(one_minus_cos));
                mul_b = signed'(MUL_B_W'(r_amp));
            end
            OP_MUL1: begin
                mul_a = signed'(MUL_A_W'(inv_alpha));
                mul_b = r_filt_mem[jsel];
            end
            OP_MUL2: begin
                mul_a = signed'(MUL_A_W'(r_alpha));
                mul_b = r_meas_vel[jsel];
            end
            OP_KP: begin
                mul_a = r_err;
                mul_b = signed'(MUL_B_W'(kp_gain(jsel)));
            end
            OP_KD: begin
                mul_a = signed'(MUL_A_W'(kd_gain(jsel)));
                mul_b = r_filt;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full = mul_a * mul_b;
    end

    always_comb begin
        ofs_sum  = r_prod + OFS_ROUND;

        filt_sum = r_acc + r_prod;
        filt_sh  = filt_sum >>> FILT_SHIFT;
        if ((&filt_sh[ACC_W-1:VEL_W-1]) || !(|filt_sh[ACC_W-1:VEL_W-1])) begin
            n_filt = filt_sh[VEL_W-1:0];
        end else if (filt_sh[ACC_W-1]) begin
            n_filt = {1'b1, {(VEL_W-1){1'b0}}};
        end else begin
            n_filt = {1'b0, {(VEL_W-1){1'b1}}};
        end

        target = ERR_W'(r_start[jsel]);
        if (jsel == OFS_JOINT_A || jsel == OFS_JOINT_B) begin
            target = target + signed'(ERR_W'(r_offset));
        end
        n_err = target - ERR_W'(r_meas_pos[jsel]);

        tq_sum = r_acc - r_prod + TQ_ROUND;
        tq_sh  = tq_sum >>> TQ_SHIFT;
        if ((&tq_sh[ACC_W-1:TQ_W-1]) || !(|tq_sh[ACC_W-1:TQ_W-1])) begin
            n_torque = tq_sh[TQ_W-1:0];
        end else if (tq_sh[ACC_W-1]) begin
            n_torque = {1'b1, {(TQ_W-1){1'b0}}};
        end else begin
            n_torque = {1'b0, {(TQ_W-1){1'b1}}};
        end

        out_free = !r_out_valid || i_ready;
        out_load = (i_cmd.op == OP_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RST;
            r_amp       <= AMP_RST;
            r_period    <= PERIOD_RST;
            r_init      <= 1'b0;
            r_mask      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < JOINTS; j++) begin
                r_filt_mem[j] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FILTER_ALPHA:     r_alpha  <= i_cfg_data[ALPHA_W-1:0];
                    CFG_OFFSET_AMPLITUDE: r_amp    <= i_cfg_data[AMP_W-1:0];
                    CFG_PERIOD_TICKS:     r_period <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.op == OP_SAMPLE && sample_ok) begin
                r_mask <= n_mask;
            end
            if (init_now) begin
                r_init  <= 1'b1;
                r_phase <= '0;
            end else if (i_cmd.op == OP_PHASE) begin
                r_phase <= n_phase;
            end

            if (i_cmd.op == OP_FILT) begin
                r_filt_mem[jsel] <= n_filt;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SAMPLE && sample_ok) begin
            r_meas_pos[i_joint_index] <= i_position;
            r_meas_vel[i_joint_index] <= i_velocity;
        end
        // Latch start positions, taking the arriving sample for its own joint
        if (init_now) begin
            for (int j = 0; j < JOINTS; j++) begin
                r_start[j] <= (JOINT_W'(j) == i_joint_index) ? i_position : r_meas_pos[j];
            end
        end

        if (i_cmd.op == OP_COS) begin
            r_cos     <= COS_TAB[cos_addr];
            r_cos_neg <= quadrant[0] ^ quadrant[1];
        end

        if (i_cmd.op == OP_OFS_MUL || i_cmd.op == OP_MUL1 || i_cmd.op == OP_MUL2 ||
            i_cmd.op == OP_KP || i_cmd.op == OP_KD) begin
            r_prod <= mul_full[ACC_W-1:0];
        end

        if (i_cmd.op == OP_OFS) begin
            r_offset <= ofs_sum[COS_FRAC+OFS_W-1:COS_FRAC];
        end

        if (i_cmd.op == OP_MUL2) begin
            r_acc <= r_prod + FILT_ROUND;
        end else if (i_cmd.op == OP_KD) begin
            r_acc <= r_prod;
        end

        if (i_cmd.op == OP_FILT) begin
            r_filt <= n_filt;
            r_err  <= n_err;
        end

        if (out_load) begin
            r_out_joint <= jsel;
            r_torque    <= n_torque;
            r_out_last  <= jsel == JOINT_W'(JOINTS - 1);
        end
    end

    assign o_status.initialized = r_init;
    assign o_status.div_done    = div_done;
    assign o_status.out_free    = out_free;

    assign o_valid     = r_out_valid;
    assign o_out_joint = r_out_joint;
    assign o_torque    = r_torque;
    assign o_last      = r_out_last;

endmodule

>>> sv/jipd_ctrl.sv
module jipd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_func,
    input  jipd_pkg::t_status  i_status,
    output logic               o_ready,
    output jipd_pkg::t_cmd     o_cmd
);
    import jipd_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_PHASE   = 13'b0000000000010,
        S_DSTART  = 13'b0000000000100,
        S_DIV     = 13'b0000000001000,
        S_COS     = 13'b0000000010000,
        S_OFS_MUL = 13'b0000000100000,
        S_OFS     = 13'b0000001000000,
        S_MUL1    = 13'b0000010000000,
        S_MUL2    = 13'b0000100000000,
        S_FILT    = 13'b0001000000000,
        S_KP      = 13'b0010000000000,
        S_KD      = 13'b0100000000000,
        S_OUT     = 13'b1000000000000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [JOINT_W-1:0]  r_joint;
    logic [JOINT_W-1:0]  n_joint;
    logic                last_joint;

    assign last_joint = r_joint == JOINT_W'(JOINTS - 1);

    always_comb begin
        n_state   = r_state;
        n_joint   = r_joint;
        o_ready   = 1'b0;
        o_cmd.op  = OP_NONE;
        o_cmd.joint = r_joint;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_func == FUNC_SAMPLE) begin
                        o_cmd.op = OP_SAMPLE;
                    end else if (i_status.initialized) begin
                        n_state = S_PHASE;
                    end
                end
            end
            S_PHASE: begin
                o_cmd.op = OP_PHASE;
                n_state  = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.op = OP_DIV_START;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_COS;
                end
            end
            S_COS: begin
                o_cmd.op = OP_COS;
                n_state  = S_OFS_MUL;
            end
            S_OFS_MUL: begin
                o_cmd.op = OP_OFS_MUL;
                n_state  = S_OFS;
            end
            S_OFS: begin
                o_cmd.op = OP_OFS;
                n_joint  = '0;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = OP_MUL1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = OP_MUL2;
                n_state  = S_FILT;
            end
            S_FILT: begin
                o_cmd.op = OP_FILT;
                n_state  = S_KP;
            end
            S_KP: begin
                o_cmd.op = OP_KP;
                n_state  = S_KD;
            end
            S_KD: begin
                o_cmd.op = OP_KD;
                n_state  = S_OUT;
            end
            S_OUT: begin
                o_cmd.op = OP_OUT;
                // Hold until the output register can take the item
                if (i_status.out_free) begin
                    if (last_joint) begin
                        n_state = S_IDLE;
                    end else begin
                        n_joint = r_joint + 1'b1;
                        n_state = S_MUL1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_joint <= '0;
        end else begin
            r_state <= n_state;
            r_joint <= n_joint;
        end
    end

endmodule

>>> sv/joint_impedance_pd_controller.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_ready          i_func, i_joint_index, i_position, i_velocity
// result    out        o_valid / i_ready          o_out_joint, o_torque, o_last
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A joint sample is taken in idle; a tick before initialization is dropped.
// An initialized tick runs: accept, phase update, a ten-bit index divide
// (start, quotient bits, done), table read, offset multiply and offset, then per
// joint the filter multiplies, filter, P and D products and output load on the one shared multiplier.
// Torque stalls hold the sequencer at the output register; ready returns the cycle
// after the seventh torque is loaded. Reset is synchronous and clears control and filters.
module joint_impedance_pd_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic [jipd_pkg::JOINT_W-1:0]        i_joint_index,
    input  logic signed [jipd_pkg::POS_W-1:0]   i_position,
    input  logic signed [jipd_pkg::VEL_W-1:0]   i_velocity,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [jipd_pkg::JOINT_W-1:0]        o_out_joint,
    output logic signed [jipd_pkg::TQ_W-1:0]    o_torque,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jipd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jipd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import jipd_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    jipd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    jipd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_joint_index (i_joint_index),
        .i_position    (i_position),
        .i_velocity    (i_velocity),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_out_joint   (o_out_joint),
        .o_torque      (o_torque),
        .o_last        (o_last)
    );

endmodule
